// File: rtl/core/dacc_pkg.sv
// Shared types and constants of the decimal accumulator processor.
`default_nettype none

package dacc_pkg;

    localparam int MEM_WORDS = 100;
    localparam int ADDR_BITS = 7;
    localparam int FIELD_BITS = 32;
    localparam int LOW_BITS = 10;

    localparam logic [LOW_BITS-1:0] DEC_BASE = 10'd100;

    localparam logic signed [63:0] SMALL_LO = 64'sd100;
    localparam logic signed [63:0] SMALL_HI = 64'sd999;
    localparam logic signed [63:0] HALT_LO = 64'sd50000;
    localparam logic signed [63:0] HALT_HI = 64'sd50099;

    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [3:0] {
        OP_LOAD   = 4'd1,
        OP_STORE  = 4'd2,
        OP_ADD    = 4'd3,
        OP_SUB    = 4'd4,
        OP_JUMP   = 4'd5,
        OP_JUMPZ  = 4'd6,
        OP_JUMPN  = 4'd7,
        OP_INPUT  = 4'd8,
        OP_OUTPUT = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OPCODE = 2'd1,
        ERR_PC     = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 is_halt;
        logic                 is_valid;
        op_t                  op;
        logic [ADDR_BITS-1:0] addr;
    } dec_t;

    function automatic logic [LOW_BITS-1:0] op_base(input logic [3:0] digit);
        return LOW_BITS'(digit) * DEC_BASE;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dacc_if.sv
// Request and response channel interfaces of the decimal accumulator processor.
`default_nettype none

interface dacc_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [6:0]         load_address;
    logic signed [31:0] load_value;
    logic signed [31:0] input_value;

    modport source (output valid, action, load_address, load_value, input_value,
                    input ready);
    modport sink (input valid, action, load_address, load_value, input_value,
                  output ready);
endinterface

interface dacc_rsp_if;
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic [1:0]         error_code;
    logic signed [31:0] acc_value;
    logic [6:0]         pc_value;

    modport source (output valid, out_valid, out_value, halted, error_code, acc_value,
                    pc_value, input ready);
    modport sink (input valid, out_valid, out_value, halted, error_code, acc_value,
                  pc_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dacc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dacc_decode.sv
// Instruction word decoder: opcode and address by range checks, no divider.
`default_nettype none

module dacc_decode
    import dacc_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic [WORD_BITS-1:0] word,
    output dec_t                      dec
);

    logic signed [WORD_BITS-1:0] word_s;
    logic signed [63:0]          word_ext;
    logic [LOW_BITS-1:0]         low;
    logic [3:0]                  digit;
    logic                        in_small;

    assign word_s   = word;
    assign word_ext = 64'(word_s);
    assign low      = word_ext[LOW_BITS-1:0];
    assign in_small = (word_ext >= SMALL_LO) && (word_ext <= SMALL_HI);

    always_comb
    begin
        digit = 4'd1;
        for (int k = 2; k <= 9; k++)
        begin
            if (low >= op_base(4'(k)))
            begin
                digit = 4'(k);
            end
        end
    end

    assign dec.is_halt  = (word_ext >= HALT_LO) && (word_ext <= HALT_HI);
    assign dec.is_valid = in_small;
    assign dec.op       = in_small ? op_t'(digit) : OP_LOAD;
    assign dec.addr     = ADDR_BITS'(low - op_base(digit));

endmodule

`default_nettype wire

// File: rtl/core/decimal_accumulator_cpu.sv
// Decimal accumulator processor: 100-word memory, accumulator and program counter.
//
// Channels: req (sink) carries one item per handshake: action 0 writes
// load_value to memory word load_address (addresses of 100 and up are
// ignored), action 1 executes the instruction at the program counter.
// rsp (source) returns exactly one item per request with the resulting
// machine state; out_valid/out_value report an OUTPUT instruction.
// Order: a load writes memory on accept and responds from the DONE state; a
// step fetches (FETCH), then reads the operand (OPER) for LOAD, ADD,
// SUB and OUTPUT, as the data memory has a single read port.
// One item is in work at a time; a new item is accepted while the
// previous response still waits in the output register.
// Reset: accumulator, program counter and flags clear; memory words read
// as zero until written (one valid bit per word), so no clearing pass.
// A stalled response holds the next item at its last cycle, with no state
// update, until the output register frees.
`default_nettype none

module decimal_accumulator_cpu
    import dacc_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dacc_req_if.sink   req,
    dacc_rsp_if.source rsp
);

    state_t state_reg, state_next;

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] pc_reg, pc_next;
    logic                 halt_reg, halt_next;
    err_t                 err_reg, err_next;
    op_t                  op_reg, op_next;
    logic [WORD_BITS-1:0] in_word_reg;
    logic [MEM_WORDS-1:0] vld_reg;
    logic                 rvld_reg;
    logic                 ovalid_reg;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] rd_word;

    logic                 out_free;
    logic                 load_out;
    logic                 emit_valid;
    logic [WORD_BITS-1:0] emit_val;
    logic                 need_oper;
    logic                 step_go;
    dec_t                 dec;

    logic signed [63:0]   load_ext;
    logic signed [63:0]   input_ext;
    logic [63:0]          acc_wide;
    logic [63:0]          emit_wide;
    logic [ADDR_BITS-1:0] pc_inc;

    dacc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dacc_decode #(
        .WORD_BITS (WORD_BITS)
    ) u_decode (
        .word (rd_word),
        .dec  (dec)
    );

    assign rd_word   = rvld_reg ? mem_rdata : '0;
    assign out_free  = !ovalid_reg || rsp.ready;
    assign load_ext  = 64'(req.load_value);
    assign input_ext = 64'(req.input_value);
    assign pc_inc    = pc_reg + ADDR_BITS'(1);
    assign step_go   = (req.action == ACT_STEP) && !halt_reg
                       && (pc_reg < ADDR_BITS'(MEM_WORDS));
    assign need_oper = dec.is_valid && !dec.is_halt
                       && (dec.op == OP_LOAD || dec.op == OP_ADD
                           || dec.op == OP_SUB || dec.op == OP_OUTPUT);

    assign req.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = step_go ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH:
            begin
                if (need_oper)
                begin
                    state_next = ST_OPER;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OPER, ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        mem_we     = 1'b0;
        mem_waddr  = req.load_address;
        mem_wdata  = load_ext[WORD_BITS-1:0];
        mem_re     = 1'b0;
        mem_raddr  = pc_reg;
        load_out   = 1'b0;
        emit_valid = 1'b0;
        emit_val   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action != ACT_STEP)
                    begin
                        mem_we = (req.load_address < ADDR_BITS'(MEM_WORDS));
                    end
                    else if (!halt_reg)
                    begin
                        if (pc_reg >= ADDR_BITS'(MEM_WORDS))
                        begin
                            halt_next = 1'b1;
                            err_next  = ERR_PC;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                if (need_oper)
                begin
                    pc_next   = pc_inc;
                    op_next   = dec.op;
                    mem_re    = 1'b1;
                    mem_raddr = dec.addr;
                end
                else if (out_free)
                begin
                    load_out = 1'b1;
                    pc_next  = pc_inc;
                    if (dec.is_halt)
                    begin
                        halt_next = 1'b1;
                    end
                    else if (!dec.is_valid)
                    begin
                        halt_next = 1'b1;
                        err_next  = ERR_OPCODE;
                    end
                    else
                    begin
                        case (dec.op)
                            OP_STORE:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = dec.addr;
                                mem_wdata = acc_reg;
                            end
                            OP_INPUT:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = dec.addr;
                                mem_wdata = in_word_reg;
                            end
                            OP_JUMP:
                            begin
                                pc_next = dec.addr;
                            end
                            OP_JUMPZ:
                            begin
                                if (acc_reg == '0)
                                begin
                                    pc_next = dec.addr;
                                end
                            end
                            OP_JUMPN:
                            begin
                                if (acc_reg[WORD_BITS-1])
                                begin
                                    pc_next = dec.addr;
                                end
                            end
                            default:
                            begin
                                pc_next = pc_inc;
                            end
                        endcase
                    end
                end
            end
            ST_OPER:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    case (op_reg)
                        OP_LOAD:
                        begin
                            acc_next = rd_word;
                        end
                        OP_ADD:
                        begin
                            acc_next = acc_reg + rd_word;
                        end
                        OP_SUB:
                        begin
                            acc_next = acc_reg - rd_word;
                        end
                        OP_OUTPUT:
                        begin
                            emit_valid = 1'b1;
                            emit_val   = rd_word;
                        end
                        default:
                        begin
                            acc_next = acc_reg;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    assign acc_wide  = 64'(acc_next);
    assign emit_wide = 64'(emit_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            acc_reg    <= '0;
            pc_reg     <= '0;
            halt_reg   <= 1'b0;
            err_reg    <= ERR_NONE;
            op_reg     <= OP_LOAD;
            vld_reg    <= '0;
            rvld_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            err_reg   <= err_next;
            op_reg    <= op_next;
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvld_reg <= vld_reg[mem_raddr];
            end
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_word_reg <= input_ext[WORD_BITS-1:0];
        end
        if (load_out)
        begin
            rsp.out_valid  <= emit_valid;
            rsp.out_value  <= emit_wide[FIELD_BITS-1:0];
            rsp.halted     <= halt_next;
            rsp.error_code <= err_next;
            rsp.acc_value  <= acc_wide[FIELD_BITS-1:0];
            rsp.pc_value   <= pc_next;
        end
    end

    assign rsp.valid = ovalid_reg;

endmodule

`default_nettype wire
